// File: rtl/core/imk_pkg.sv
// ----------------------------------------------------------------------------
// imk_pkg
// Shared types, codes and the symbol table of the iambic Morse keyer and
// decoder.
// ----------------------------------------------------------------------------
package imk_pkg;

  // Keyer states
  typedef enum logic [2:0] {
    KS_IDLE = 3'd0,
    KS_DOT  = 3'd1,
    KS_DASH = 3'd2,
    KS_GAP1 = 3'd3,
    KS_GAP2 = 3'd4,
    KS_TUNE = 3'd5
  } imk_kstate_t;

  // Paddle that started an element
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_DOT  = 2'd1,
    PAD_DASH = 2'd2
  } imk_pad_t;

  // Tune commands
  localparam logic [1:0] TUNE_NONE  = 2'd0;
  localparam logic [1:0] TUNE_ENTER = 2'd1;
  localparam logic [1:0] TUNE_LEAVE = 2'd2;

  // Keyer modes (two and three are both Ultimatic)
  localparam logic [1:0] MODE_IAMBIC_A = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_B = 2'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_STRAIGHT_KEY = 2'd0;
  localparam logic [1:0] CFG_DOT_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_KEYER_MODE   = 2'd2;

  // Widths and reset values
  localparam int DOT_W  = 11;
  localparam int CODE_W = 6;
  localparam logic [DOT_W-1:0] DOT_LENGTH_RESET = 11'd60;

  // Reciprocal of three for an 11-bit dividend: x/3 == (x*683) >> 11
  localparam logic [21:0] THIRD_MUL = 22'd683;

  localparam int NUM_SYMBOLS = 43;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 6'd43;

  // Element patterns, two bits per element (01 dot, 10 dash)
  localparam logic [11:0] SYMBOL_TABLE [NUM_SYMBOLS] = '{
    12'h006, 12'h095, 12'h099, 12'h025, 12'h001, 12'h059, 12'h029, 12'h055,
    12'h005, 12'h06A, 12'h026, 12'h065, 12'h00A, 12'h009, 12'h02A, 12'h069,
    12'h0A6, 12'h019, 12'h015, 12'h002, 12'h016, 12'h056, 12'h01A, 12'h096,
    12'h09A, 12'h0A5,
    12'h2AA, 12'h1AA, 12'h16A, 12'h15A, 12'h156, 12'h155, 12'h255, 12'h295,
    12'h2A5, 12'h2A9,
    12'h5A5, 12'h256, 12'h666, 12'hA5A, 12'h199, 12'h566, 12'h269
  };

  typedef struct packed {
    logic             straight_key;
    logic [DOT_W-1:0] dot_length_ms;
    logic [1:0]       keyer_mode;
  } imk_cfg_t;

  typedef struct packed {
    imk_kstate_t keyer;
    logic [31:0] now_ms;
    logic [31:0] next_scan_ms;
    logic [31:0] second_gap_end_ms;
    logic [31:0] char_gap_start_ms;
    logic        char_gap_armed;
    logic [31:0] word_gap_start_ms;
    logic        word_gap_armed;
    logic [31:0] element_pattern;
    logic        dot_memory;
    logic        dash_memory;
    logic        squeezed;
    imk_pad_t    current_paddle;
    imk_pad_t    first_paddle;
  } imk_state_t;

  typedef struct packed {
    logic              key_down;
    logic              busy_res;
    logic              tune_active;
    logic              symbol_valid;
    logic [CODE_W-1:0] symbol_code;
    logic              word_space;
  } imk_result_t;

  // Look up a packed element pattern; anything unlisted is unknown
  function automatic logic [CODE_W-1:0] decode_symbol(input logic [31:0] pat);
    logic [CODE_W-1:0] code;
    code = CODE_UNKNOWN;
    for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
      if (pat[31:12] == 20'd0 && pat[11:0] == SYMBOL_TABLE[i]) begin
        code = CODE_W'(i);
      end
    end
    return code;
  endfunction

endpackage

// File: rtl/core/iambic_morse_keyer_decoder.sv
// ----------------------------------------------------------------------------
// iambic_morse_keyer_decoder
// Iambic A/B and Ultimatic Morse keyer with straight key and tune modes, and
// a decoder that turns sent elements into symbol codes and word spaces.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying both paddle levels and a
// tune command; each tick yields exactly one result beat. The block takes a
// new tick every clock cycle while in_stall is low. A tick is held in the
// input register, then goes through the step logic into the result register,
// where the keyer state is also updated. A stalled result holds both stages;
// the input side stalls only when both are full. Configuration writes are
// always ready and take effect on the next tick; write them only while no
// tick is in flight.
module iambic_morse_keyer_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input ticks
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_dot_paddle,
  input  logic        in_dash_paddle,
  input  logic [1:0]  in_tune_command,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_key_down,
  output logic        out_busy_res,
  output logic        out_tune_active,
  output logic        out_symbol_valid,
  output logic [5:0]  out_symbol_code,
  output logic        out_word_space,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  imk_pkg::imk_cfg_t    cfg_r;
  imk_pkg::imk_state_t  state_r, state_nxt;
  imk_pkg::imk_result_t res_nxt, out_res_r;

  logic       s1_valid_r;
  logic       s1_dot_r;
  logic       s1_dash_r;
  logic [1:0] s1_tune_r;
  logic       out_valid_r;

  logic out_free;
  logic s2_load;
  logic in_load;

  // Handshake: stage two advances when the result slot is free
  assign out_free = !out_valid_r || !out_stall;
  assign s2_load  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_load  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.straight_key  <= 1'b1;
      cfg_r.dot_length_ms <= imk_pkg::DOT_LENGTH_RESET;
      cfg_r.keyer_mode    <= imk_pkg::MODE_IAMBIC_A;
    end else if (cfg_valid) begin
      case (cfg_index)
        imk_pkg::CFG_STRAIGHT_KEY: cfg_r.straight_key  <= cfg_data[0];
        imk_pkg::CFG_DOT_LENGTH:   cfg_r.dot_length_ms <= cfg_data;
        imk_pkg::CFG_KEYER_MODE:   cfg_r.keyer_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_dot_r  <= in_dot_paddle;
      s1_dash_r <= in_dash_paddle;
      s1_tune_r <= in_tune_command;
    end
  end

  imk_step u_step (
    .cur      (state_r),
    .cfg      (cfg_r),
    .dot      (s1_dot_r),
    .dash     (s1_dash_r),
    .tune_cmd (s1_tune_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  // Keyer state: advance once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.keyer             <= imk_pkg::KS_IDLE;
      state_r.now_ms            <= 32'd0;
      state_r.next_scan_ms      <= 32'd0;
      state_r.second_gap_end_ms <= 32'd0;
      state_r.char_gap_start_ms <= 32'd0;
      state_r.char_gap_armed    <= 1'b0;
      state_r.word_gap_start_ms <= 32'd0;
      state_r.word_gap_armed    <= 1'b0;
      state_r.element_pattern   <= 32'd0;
      state_r.dot_memory        <= 1'b0;
      state_r.dash_memory       <= 1'b0;
      state_r.squeezed          <= 1'b0;
      state_r.current_paddle    <= imk_pkg::PAD_NONE;
      state_r.first_paddle      <= imk_pkg::PAD_NONE;
    end else if (s2_load) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_down     = out_res_r.key_down;
  assign out_busy_res     = out_res_r.busy_res;
  assign out_tune_active  = out_res_r.tune_active;
  assign out_symbol_valid = out_res_r.symbol_valid;
  assign out_symbol_code  = out_res_r.symbol_code;
  assign out_word_space   = out_res_r.word_space;

`ifndef ASSERT_OFF
  // the tick counter moves by exactly one per processed tick
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(s2_load) |-> state_r.now_ms == $past(state_r.now_ms) + 32'd1)
    else $error("tick counter did not advance by one");

  // no symbol code without a decoded character
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.symbol_valid |-> out_res_r.symbol_code == 6'd0)
    else $error("symbol code set without a symbol");

  // keyed and tune imply busy
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.key_down || out_res_r.tune_active) |-> out_res_r.busy_res)
    else $error("keyed while idle");

  // decode and word space happen only with the keyer idle
  a_flags_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.symbol_valid || out_res_r.word_space) |->
      !out_res_r.busy_res)
    else $error("symbol or word space flagged while busy");
`endif

endmodule

// File: rtl/core/imk_step.sv
// ----------------------------------------------------------------------------
// imk_step
// Next-state and result logic for one millisecond tick: tune command,
// straight key or paddle keyer scan, character and word gap detection.
// ----------------------------------------------------------------------------
module imk_step (
  input  imk_pkg::imk_state_t  cur,
  input  imk_pkg::imk_cfg_t    cfg,
  input  logic                 dot,
  input  logic                 dash,
  input  logic [1:0]           tune_cmd,
  output imk_pkg::imk_state_t  nxt,
  output imk_pkg::imk_result_t res
);

  logic [31:0] t;
  logic [31:0] delay;
  logic [21:0] third_prod;
  logic [10:0] dot_third;
  logic [12:0] dot_len_x3;
  logic [12:0] word_len;
  logic        want_dot;
  logic        want_dash;
  logic        dot_first;
  logic        dash_sel;
  imk_pkg::imk_pad_t pad_sel;

  assign t          = cur.now_ms;
  assign third_prod = {11'd0, cfg.dot_length_ms} * imk_pkg::THIRD_MUL;
  assign dot_third  = third_prod[21:11];
  assign dot_len_x3 = {2'b00, cfg.dot_length_ms} + {1'b0, cfg.dot_length_ms, 1'b0};
  assign word_len   = {cfg.dot_length_ms, 2'b00};

  // Advance the keyer by one tick
  always_comb begin
    nxt          = cur;
    res          = '0;
    delay        = 32'd0;
    want_dot     = 1'b0;
    want_dash    = 1'b0;
    dot_first    = 1'b0;
    dash_sel     = 1'b0;
    pad_sel      = imk_pkg::PAD_NONE;

    // apply tune command before the scan
    case (tune_cmd)
      imk_pkg::TUNE_ENTER: nxt.keyer = imk_pkg::KS_TUNE;
      imk_pkg::TUNE_LEAVE: nxt.keyer = imk_pkg::KS_IDLE;
      default: ;
    endcase

    if (dot && dash) begin
      nxt.squeezed = 1'b1;
    end

    if (cfg.straight_key) begin
      // straight key: dot contact keys, dash enters tune, dot leaves it
      if (nxt.keyer == imk_pkg::KS_TUNE) begin
        if (dot) begin
          nxt.keyer = imk_pkg::KS_IDLE;
        end
      end else if (nxt.keyer == imk_pkg::KS_IDLE) begin
        if (dash) begin
          nxt.keyer = imk_pkg::KS_TUNE;
        end else if (dot) begin
          nxt.keyer = imk_pkg::KS_DOT;
        end
      end else if (!dot) begin
        nxt.keyer = imk_pkg::KS_IDLE;
      end
    end else begin
      // remember presses in the second part of the gap
      if (nxt.keyer == imk_pkg::KS_GAP2) begin
        if (dot) begin
          nxt.dot_memory = 1'b1;
        end
        if (dash) begin
          nxt.dash_memory = 1'b1;
        end
      end

      if (t > cur.next_scan_ms) begin
        case (nxt.keyer)
          imk_pkg::KS_DOT, imk_pkg::KS_DASH: begin
            nxt.keyer             = imk_pkg::KS_GAP1;
            delay                 = {21'd0, dot_third};
            nxt.second_gap_end_ms = t + {21'd0, cfg.dot_length_ms};
            nxt.char_gap_start_ms = t;
            nxt.char_gap_armed    = 1'b1;
            nxt.word_gap_armed    = 1'b0;
          end
          imk_pkg::KS_GAP1: begin
            nxt.keyer = imk_pkg::KS_GAP2;
            delay = (t >= cur.second_gap_end_ms) ? 32'd0 : cur.second_gap_end_ms - t;
          end
          imk_pkg::KS_GAP2: begin
            nxt.keyer = imk_pkg::KS_IDLE;
            // iambic B: add the opposite element after a released squeeze
            if (cfg.keyer_mode == imk_pkg::MODE_IAMBIC_B && nxt.squeezed &&
                !(dot || nxt.dot_memory || dash || nxt.dash_memory)) begin
              if (cur.current_paddle == imk_pkg::PAD_DOT) begin
                nxt.dash_memory = 1'b1;
              end else begin
                nxt.dot_memory = 1'b1;
              end
            end
            nxt.squeezed = 1'b0;
          end
          imk_pkg::KS_IDLE: begin
            want_dot  = dot || nxt.dot_memory;
            want_dash = dash || nxt.dash_memory;
            if (want_dot || want_dash) begin
              if (cfg.keyer_mode == imk_pkg::MODE_IAMBIC_A ||
                  cfg.keyer_mode == imk_pkg::MODE_IAMBIC_B) begin
                dot_first = cur.current_paddle != imk_pkg::PAD_DOT;
              end else begin
                dot_first = cur.first_paddle != imk_pkg::PAD_DOT;
              end
              dash_sel = dot_first ? !want_dot : want_dash;
              pad_sel  = dash_sel ? imk_pkg::PAD_DASH : imk_pkg::PAD_DOT;
              // start the element and shift it into the pattern
              nxt.keyer           = dash_sel ? imk_pkg::KS_DASH : imk_pkg::KS_DOT;
              nxt.element_pattern = {cur.element_pattern[29:0], dash_sel, !dash_sel};
              nxt.current_paddle  = pad_sel;
              if (cur.first_paddle == imk_pkg::PAD_NONE) begin
                nxt.first_paddle = pad_sel;
              end
              delay = dash_sel ? {19'd0, dot_len_x3} : {21'd0, cfg.dot_length_ms};
              nxt.dot_memory  = 1'b0;
              nxt.dash_memory = 1'b0;
            end else begin
              nxt.first_paddle   = imk_pkg::PAD_NONE;
              nxt.current_paddle = imk_pkg::PAD_NONE;
              // character gap over: decode and arm the word gap
              if (cur.char_gap_armed &&
                  (t - cur.char_gap_start_ms) >= {19'd0, dot_len_x3}) begin
                res.symbol_valid      = 1'b1;
                res.symbol_code       = imk_pkg::decode_symbol(cur.element_pattern);
                nxt.element_pattern   = 32'd0;
                nxt.char_gap_armed    = 1'b0;
                nxt.word_gap_start_ms = t;
                nxt.word_gap_armed    = 1'b1;
              end
            end
          end
          default: ;
        endcase
        nxt.next_scan_ms = t + delay;
      end

      // flag a word space once the longer gap has run
      if (nxt.keyer == imk_pkg::KS_IDLE && nxt.word_gap_armed &&
          (t - nxt.word_gap_start_ms) >= {19'd0, word_len}) begin
        res.word_space     = 1'b1;
        nxt.word_gap_armed = 1'b0;
      end
    end

    nxt.now_ms = t + 32'd1;

    res.key_down    = nxt.keyer inside {imk_pkg::KS_DOT, imk_pkg::KS_DASH, imk_pkg::KS_TUNE};
    res.busy_res    = nxt.keyer != imk_pkg::KS_IDLE;
    res.tune_active = nxt.keyer == imk_pkg::KS_TUNE;
  end

endmodule
